@@ hdl/twsdl_pkg.sv @@
// Shared types, codes and constants of the three-wire serial display link master.
package twsdl_pkg;

   // Transfer lengths in bits
   localparam int READ_BITS   = 32;
   localparam int SEND_BITS   = 8;
   localparam int BIT_IDX_W   = $clog2(READ_BITS + 1);
   localparam int SHIFT_IDX_W = $clog2(READ_BITS);

   // Field widths
   localparam int FUNC_W = 2;
   localparam int BYTE_W = 8;
   localparam int TICK_W = 16;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_HALF   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_PHASE = 2'd1;
   localparam logic [TICK_W-1:0] LOW_HALF_RESET   = 16'h0fff;
   localparam logic [TICK_W-1:0] HIGH_PHASE_RESET = 16'h1fff;

   // Request function codes on the input channel
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CMD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DATA = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd3;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Bit subphases
   typedef enum logic [2:0] {
      SUB_LOW_A = 3'b001,
      SUB_LOW_B = 3'b010,
      SUB_HIGH  = 3'b100
   } sub_type;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_CMD  = 2'd1,
      REQ_DATA = 2'd2,
      REQ_READ = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [BYTE_W-1:0] byte_value;
      logic              dio_in;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'b001,
      MODE_SEND = 3'b010,
      MODE_READ = 3'b100
   } mode_type;

endpackage

@@ hdl/twsdl_front.sv @@
// Front part: accepts tick beats, classifies the request and queues it for the back part.
module twsdl_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [twsdl_pkg::FUNC_W-1:0]      req_func,
   input  logic [twsdl_pkg::BYTE_W-1:0]      req_byte_value,
   input  logic                              req_dio_in,
   output twsdl_pkg::queue_head_type         head,
   input  logic                              pop
);

   twsdl_pkg::queue_entry_type             entry_ff [twsdl_pkg::QUEUE_DEPTH];
   twsdl_pkg::queue_entry_type             new_entry;
   logic [twsdl_pkg::QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [twsdl_pkg::QPTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [twsdl_pkg::QCNT_W-1:0]           count_ff, count_in;
   logic                                   push;
   logic                                   do_pop;

   // Classify the incoming beat
   always_comb begin
      new_entry.byte_value = req_byte_value;
      new_entry.dio_in     = req_dio_in;
      case (req_func)
         twsdl_pkg::FUNC_CMD:  new_entry.kind = twsdl_pkg::REQ_CMD;
         twsdl_pkg::FUNC_DATA: new_entry.kind = twsdl_pkg::REQ_DATA;
         twsdl_pkg::FUNC_READ: new_entry.kind = twsdl_pkg::REQ_READ;
         default:              new_entry.kind = twsdl_pkg::REQ_TICK;
      endcase
   end

   assign req_ready = (count_ff != twsdl_pkg::QCNT_W'(twsdl_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == twsdl_pkg::QPTR_W'(twsdl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == twsdl_pkg::QPTR_W'(twsdl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

@@ hdl/twsdl_back.sv @@
// Back part: runs the link timing one tick per queued beat and registers the result beat.
module twsdl_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [twsdl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [twsdl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  twsdl_pkg::queue_head_type           head,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_strobe_pin,
   output logic                                rsp_clock_pin,
   output logic                                rsp_data_out_pin,
   output logic                                rsp_data_drive,
   output logic                                rsp_busy_res,
   output logic                                rsp_request_rejected,
   output logic [twsdl_pkg::READ_BITS-1:0]     rsp_read_word,
   output logic                                rsp_read_valid
);

   // Timing registers
   logic [twsdl_pkg::TICK_W-1:0]    low_half_ff, high_phase_ff;

   // Link state
   twsdl_pkg::mode_type             mode_ff, mode_in;
   logic [twsdl_pkg::BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in, bit_next;
   twsdl_pkg::sub_type              sub_ff, sub_in;
   logic [twsdl_pkg::TICK_W-1:0]    cnt_ff, cnt_in;
   logic [twsdl_pkg::READ_BITS-1:0] shift_ff, shift_in;
   logic                            stb_ff, stb_in;
   logic                            clk_ff, clk_in;
   logic                            dat_ff, dat_in;
   logic                            drv_ff, drv_in;
   logic                            pend_ff, pend_in;

   // Step results
   logic                            rejected;
   logic                            word_valid;
   logic [twsdl_pkg::READ_BITS-1:0] word;
   logic [twsdl_pkg::TICK_W-1:0]    len_sel, len_eff;
   logic                            last_bit;

   // Output register
   logic                            out_valid_ff;
   logic                            out_stb_ff, out_clk_ff, out_dat_ff, out_drv_ff;
   logic                            out_busy_ff, out_rej_ff, out_rvalid_ff;
   logic [twsdl_pkg::READ_BITS-1:0] out_word_ff;

   twsdl_pkg::queue_entry_type      beat;

   assign beat = head.entry;
   assign pop  = head.valid && (!out_valid_ff || rsp_ready);

   // Write timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_half_ff   <= twsdl_pkg::LOW_HALF_RESET;
         high_phase_ff <= twsdl_pkg::HIGH_PHASE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == twsdl_pkg::CSR_LOW_HALF) begin
            low_half_ff <= csr_wdata;
         end else if (csr_index == twsdl_pkg::CSR_HIGH_PHASE) begin
            high_phase_ff <= csr_wdata;
         end
      end
   end

   // Phase length, zero counts as one tick
   assign len_sel  = (sub_ff == twsdl_pkg::SUB_HIGH) ? high_phase_ff : low_half_ff;
   assign len_eff  = (len_sel == '0) ? twsdl_pkg::TICK_W'(1) : len_sel;
   assign bit_next = bit_idx_ff + 1'b1;
   assign last_bit = (mode_ff == twsdl_pkg::MODE_READ) ?
                     (bit_next >= twsdl_pkg::BIT_IDX_W'(twsdl_pkg::READ_BITS)) :
                     (bit_next >= twsdl_pkg::BIT_IDX_W'(twsdl_pkg::SEND_BITS));

   // Advance the link by one tick
   always_comb begin
      mode_in    = mode_ff;
      bit_idx_in = bit_idx_ff;
      sub_in     = sub_ff;
      cnt_in     = cnt_ff;
      shift_in   = shift_ff;
      stb_in     = stb_ff;
      clk_in     = clk_ff;
      dat_in     = dat_ff;
      drv_in     = drv_ff;
      pend_in    = pend_ff;
      rejected   = 1'b0;
      word_valid = 1'b0;
      word       = '0;
      if (mode_ff != twsdl_pkg::MODE_IDLE) begin
         rejected = (beat.kind != twsdl_pkg::REQ_TICK);
         if (pend_ff) begin
            // end the command strobe pulse and open the first bit
            pend_in = 1'b0;
            stb_in  = 1'b0;
            clk_in  = 1'b0;
            sub_in  = twsdl_pkg::SUB_LOW_A;
            cnt_in  = twsdl_pkg::TICK_W'(1);
         end else if (cnt_ff < len_eff) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            case (sub_ff)
               twsdl_pkg::SUB_LOW_A: begin
                  sub_in = twsdl_pkg::SUB_LOW_B;
                  cnt_in = twsdl_pkg::TICK_W'(1);
                  if (mode_ff == twsdl_pkg::MODE_READ) begin
                     if (beat.dio_in) begin
                        shift_in[bit_idx_ff[twsdl_pkg::SHIFT_IDX_W-1:0]] = 1'b1;
                     end
                  end else begin
                     dat_in   = shift_ff[0];
                     shift_in = shift_ff >> 1;
                  end
               end
               twsdl_pkg::SUB_LOW_B: begin
                  sub_in = twsdl_pkg::SUB_HIGH;
                  cnt_in = twsdl_pkg::TICK_W'(1);
                  clk_in = 1'b1;
               end
               default: begin
                  if (last_bit) begin
                     if (mode_ff == twsdl_pkg::MODE_READ) begin
                        word       = shift_ff;
                        word_valid = 1'b1;
                     end
                     mode_in    = twsdl_pkg::MODE_IDLE;
                     bit_idx_in = '0;
                     sub_in     = twsdl_pkg::SUB_LOW_A;
                     cnt_in     = '0;
                  end else begin
                     bit_idx_in = bit_next;
                     clk_in     = 1'b0;
                     sub_in     = twsdl_pkg::SUB_LOW_A;
                     cnt_in     = twsdl_pkg::TICK_W'(1);
                  end
               end
            endcase
         end
      end else begin
         // start a new transfer from idle
         case (beat.kind)
            twsdl_pkg::REQ_CMD: begin
               bit_idx_in = '0;
               stb_in     = 1'b1;
               drv_in     = 1'b1;
               mode_in    = twsdl_pkg::MODE_SEND;
               shift_in   = twsdl_pkg::READ_BITS'(beat.byte_value);
               pend_in    = 1'b1;
               sub_in     = twsdl_pkg::SUB_LOW_A;
               cnt_in     = '0;
            end
            twsdl_pkg::REQ_DATA: begin
               bit_idx_in = '0;
               drv_in     = 1'b1;
               mode_in    = twsdl_pkg::MODE_SEND;
               shift_in   = twsdl_pkg::READ_BITS'(beat.byte_value);
               clk_in     = 1'b0;
               sub_in     = twsdl_pkg::SUB_LOW_A;
               cnt_in     = twsdl_pkg::TICK_W'(1);
            end
            twsdl_pkg::REQ_READ: begin
               bit_idx_in = '0;
               drv_in     = 1'b0;
               mode_in    = twsdl_pkg::MODE_READ;
               shift_in   = '0;
               clk_in     = 1'b0;
               sub_in     = twsdl_pkg::SUB_LOW_A;
               cnt_in     = twsdl_pkg::TICK_W'(1);
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Hold link state, advance on each popped beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= twsdl_pkg::MODE_IDLE;
         bit_idx_ff <= '0;
         sub_ff     <= twsdl_pkg::SUB_LOW_A;
         cnt_ff     <= '0;
         shift_ff   <= '0;
         stb_ff     <= 1'b1;
         clk_ff     <= 1'b1;
         dat_ff     <= 1'b0;
         drv_ff     <= 1'b0;
         pend_ff    <= 1'b0;
      end else if (pop) begin
         mode_ff    <= mode_in;
         bit_idx_ff <= bit_idx_in;
         sub_ff     <= sub_in;
         cnt_ff     <= cnt_in;
         shift_ff   <= shift_in;
         stb_ff     <= stb_in;
         clk_ff     <= clk_in;
         dat_ff     <= dat_in;
         drv_ff     <= drv_in;
         pend_ff    <= pend_in;
      end
   end

   // Output beat valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output beat payload
   always_ff @(posedge clock) begin
      if (pop) begin
         out_stb_ff    <= stb_in;
         out_clk_ff    <= clk_in;
         out_dat_ff    <= dat_in;
         out_drv_ff    <= drv_in;
         out_busy_ff   <= (mode_in != twsdl_pkg::MODE_IDLE);
         out_rej_ff    <= rejected;
         out_word_ff   <= word;
         out_rvalid_ff <= word_valid;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_strobe_pin       = out_stb_ff;
   assign rsp_clock_pin        = out_clk_ff;
   assign rsp_data_out_pin     = out_dat_ff;
   assign rsp_data_drive       = out_drv_ff;
   assign rsp_busy_res         = out_busy_ff;
   assign rsp_request_rejected = out_rej_ff;
   assign rsp_read_word        = out_word_ff;
   assign rsp_read_valid       = out_rvalid_ff;

endmodule

@@ hdl/three_wire_serial_display_link_master_top.sv @@
// Top level of the three-wire serial display link master.
//
// Each beat on the req_ channel is one tick of the link timer and may carry a
// request (command byte, data byte or 32-bit read). Each tick gives exactly one
// beat on the rsp_ channel with the pin levels after that tick, busy, reject
// flag and, at the end of a read, the received word.
// The csr_ port writes the two phase-length registers (index 0 low half,
// index 1 high phase); write only while no tick is outstanding.
// A tick is queued, then shown on rsp_ once popped into the output register.
// Throughput: one tick per cycle while rsp_ready holds; the back part steps the
// link once per cycle, popping one queued tick and loading the output register.
// A two-entry queue parts the front from the back; when the receiver stalls,
// the output register holds, the back stops and the queue fills, after which
// req_ready drops until a beat is taken.
// Reset: registers return to 4095 and 8191, the link goes idle with strobe and
// clock high and data released; queue and output register empty.
module three_wire_serial_display_link_master_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [twsdl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [twsdl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [twsdl_pkg::FUNC_W-1:0]      req_func,
   input  logic [twsdl_pkg::BYTE_W-1:0]      req_byte_value,
   input  logic                              req_dio_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_strobe_pin,
   output logic                              rsp_clock_pin,
   output logic                              rsp_data_out_pin,
   output logic                              rsp_data_drive,
   output logic                              rsp_busy_res,
   output logic                              rsp_request_rejected,
   output logic [twsdl_pkg::READ_BITS-1:0]   rsp_read_word,
   output logic                              rsp_read_valid
);

   twsdl_pkg::queue_head_type head;
   logic                      pop;

   // Accept and classify
   twsdl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_byte_value (req_byte_value),
      .req_dio_in     (req_dio_in),
      .head           (head),
      .pop            (pop)
   );

   // Run the link
   twsdl_back u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .head                 (head),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_strobe_pin       (rsp_strobe_pin),
      .rsp_clock_pin        (rsp_clock_pin),
      .rsp_data_out_pin     (rsp_data_out_pin),
      .rsp_data_drive       (rsp_data_drive),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_request_rejected (rsp_request_rejected),
      .rsp_read_word        (rsp_read_word),
      .rsp_read_valid       (rsp_read_valid)
   );

endmodule
